// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the boot guard RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define CLG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("boot guard assertion failed");
// Next-cycle implication, disabled during reset.
`define CLG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("boot guard assertion failed");
`else
`define CLG_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CLG_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/clg_pkg.sv =====
// Types and constants of the crash-loop boot guard.
package clg_pkg;

   localparam int COUNT_BITS = 8;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [7:0] THRESHOLD_RESET = 8'd3;

   typedef logic [COUNT_BITS-1:0] count_type;

   // Event codes of a request transaction
   typedef enum logic [2:0] {
      EV_POWER_ON_CLEAR = 3'd0,
      EV_DECIDE         = 3'd1,
      EV_MARK_PENDING   = 3'd2,
      EV_CLEAR_PENDING  = 3'd3,
      EV_WRITE_REQUEST  = 3'd4,
      EV_CACHE_STORE    = 3'd5,
      EV_CACHE_CLEAR    = 3'd6,
      EV_CACHE_MATCH    = 3'd7
   } req_kind_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FAILURE_THRESHOLD = 2'd0,
      CSR_UPDATE_MAGIC      = 2'd1,
      CSR_CACHE_MASK        = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic        power_on_reset;
      logic        software_reset;
      logic        watchdog_reset;
      logic        image_valid;
      logic [31:0] image_crc;
      logic [31:0] request_value;
   } req_payload_type;

   typedef struct packed {
      logic       enter_update_mode;
      logic       cache_hit;
      logic [7:0] failure_count_now;
      logic       force_update_now;
      logic       boot_pending_now;
   } rsp_payload_type;

endpackage

// ===== rtl/clg_if.sv =====
// Request and response channel interfaces of the boot guard.
interface clg_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic        power_on_reset;
   logic        software_reset;
   logic        watchdog_reset;
   logic        image_valid;
   logic [31:0] image_crc;
   logic [31:0] request_value;

   modport source (output valid, output req_type, output power_on_reset,
                   output software_reset, output watchdog_reset, output image_valid,
                   output image_crc, output request_value, input ready);
   modport sink (input valid, input req_type, input power_on_reset,
                 input software_reset, input watchdog_reset, input image_valid,
                 input image_crc, input request_value, output ready);
endinterface

interface clg_rsp_if;
   logic       valid;
   logic       ready;
   logic       enter_update_mode;
   logic       cache_hit;
   logic [7:0] failure_count_now;
   logic       force_update_now;
   logic       boot_pending_now;

   modport source (output valid, output enter_update_mode, output cache_hit,
                   output failure_count_now, output force_update_now,
                   output boot_pending_now, input ready);
   modport sink (input valid, input enter_update_mode, input cache_hit,
                 input failure_count_now, input force_update_now,
                 input boot_pending_now, output ready);
endinterface

// ===== rtl/crash_loop_update_mode_guard_top.sv =====
// Top level of the crash-loop boot guard: event pipeline and retained state.
//
//   channel   direction  handshake      payload
//   req_chan  in         valid/ready    event type, reset cause flags, image crc, request
//   rsp_chan  out        valid/ready    enter/hit flags, count, force and pending flags
//   csr_*     in         write enable   index (2 bits), data (32 bits)
//
// One event per cycle while the response channel does not stall: an event is registered
// on acceptance, and when it leaves the input register its state update is applied
// and its response registered. The retained state loop closes through that update.
// Reset is synchronous and restores all retained state and configuration.
// A stalled response holds the pipe; the input register still frees when it advances.
`include "assert_macros.svh"

module crash_loop_update_mode_guard_top
   import clg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   clg_req_if.sink                   req_chan,
   clg_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data
);

   // Configuration registers
   logic [7:0]  threshold_ff;
   logic [31:0] magic_ff;
   logic [31:0] mask_ff;

   // Retained state
   logic [31:0] request_word_ff, request_word_in;
   logic        boot_pending_ff, boot_pending_in;
   logic        force_update_ff, force_update_in;
   count_type   failure_count_ff, failure_count_in;
   logic [31:0] bad_crc_ff, bad_crc_in;
   logic [31:0] auth_cache_ff, auth_cache_in;

   // Pipeline registers
   logic            s1_valid_ff;
   req_payload_type s1_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;

   logic out_free;
   logic s1_fire;
   logic req_fire;

   assign out_free      = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire       = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_fire      = req_chan.valid && req_chan.ready;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         magic_ff     <= '0;
         mask_ff      <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FAILURE_THRESHOLD: threshold_ff <= csr_wr_data[7:0];
            CSR_UPDATE_MAGIC:      magic_ff     <= csr_wr_data;
            CSR_CACHE_MASK:        mask_ff      <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Capture an accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else if (req_fire) begin
         s1_ff.req_type       <= req_chan.req_type;
         s1_ff.power_on_reset <= req_chan.power_on_reset;
         s1_ff.software_reset <= req_chan.software_reset;
         s1_ff.watchdog_reset <= req_chan.watchdog_reset;
         s1_ff.image_valid    <= req_chan.image_valid;
         s1_ff.image_crc      <= req_chan.image_crc;
         s1_ff.request_value  <= req_chan.request_value;
      end
   end

   // Apply the event to the retained state and form the response
   always_comb begin
      logic enter;
      logic hit;
      enter            = 1'b0;
      hit              = 1'b0;
      request_word_in  = request_word_ff;
      boot_pending_in  = boot_pending_ff;
      force_update_in  = force_update_ff;
      failure_count_in = failure_count_ff;
      bad_crc_in       = bad_crc_ff;
      auth_cache_in    = auth_cache_ff;

      unique case (req_kind_type'(s1_ff.req_type))
         EV_POWER_ON_CLEAR: begin
            if (s1_ff.power_on_reset) begin
               request_word_in  = '0;
               boot_pending_in  = 1'b0;
               force_update_in  = 1'b0;
               failure_count_in = '0;
               bad_crc_in       = '0;
               auth_cache_in    = '0;
            end
         end
         EV_DECIDE: begin
            if (s1_ff.software_reset && request_word_ff == magic_ff) begin
               // grant the requested update and drop all crash history
               request_word_in  = '0;
               boot_pending_in  = 1'b0;
               force_update_in  = 1'b0;
               failure_count_in = '0;
               bad_crc_in       = '0;
               enter            = 1'b1;
            end else begin
               // count a watchdog reset during a pending boot, saturating
               if (s1_ff.watchdog_reset && boot_pending_ff &&
                   failure_count_ff != COUNT_MAX) begin
                  failure_count_in = failure_count_ff + count_type'(1);
               end
               // release a forced update once a different valid image appears
               if (force_update_ff) begin
                  if (s1_ff.image_valid && bad_crc_ff != '0 &&
                      s1_ff.image_crc != bad_crc_ff) begin
                     force_update_in  = 1'b0;
                     boot_pending_in  = 1'b0;
                     failure_count_in = '0;
                     bad_crc_in       = '0;
                  end else begin
                     enter = 1'b1;
                  end
               end
               // force update once the threshold is reached
               if (!enter && boot_pending_in &&
                   8'(failure_count_in) >= threshold_ff) begin
                  force_update_in = 1'b1;
                  boot_pending_in = 1'b0;
                  if (bad_crc_in == '0 && s1_ff.image_valid) begin
                     bad_crc_in = s1_ff.image_crc;
                  end
                  enter = 1'b1;
               end
            end
         end
         EV_MARK_PENDING:  boot_pending_in = 1'b1;
         EV_CLEAR_PENDING: boot_pending_in = 1'b0;
         EV_WRITE_REQUEST: request_word_in = s1_ff.request_value;
         EV_CACHE_STORE:   auth_cache_in   = s1_ff.image_crc ^ mask_ff;
         EV_CACHE_CLEAR:   auth_cache_in   = '0;
         EV_CACHE_MATCH: begin
            hit = auth_cache_ff != '0 && (auth_cache_ff ^ mask_ff) == s1_ff.image_crc;
         end
      endcase

      rsp_in.enter_update_mode = enter;
      rsp_in.cache_hit         = hit;
      rsp_in.failure_count_now = 8'(failure_count_in);
      rsp_in.force_update_now  = force_update_in;
      rsp_in.boot_pending_now  = boot_pending_in;
   end

   // Advance retained state when the event leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         request_word_ff  <= '0;
         boot_pending_ff  <= 1'b0;
         force_update_ff  <= 1'b0;
         failure_count_ff <= '0;
         bad_crc_ff       <= '0;
         auth_cache_ff    <= '0;
      end else if (s1_fire) begin
         request_word_ff  <= request_word_in;
         boot_pending_ff  <= boot_pending_in;
         force_update_ff  <= force_update_in;
         failure_count_ff <= failure_count_in;
         bad_crc_ff       <= bad_crc_in;
         auth_cache_ff    <= auth_cache_in;
      end
   end

   // Hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.enter_update_mode = rsp_ff.enter_update_mode;
   assign rsp_chan.cache_hit         = rsp_ff.cache_hit;
   assign rsp_chan.failure_count_now = rsp_ff.failure_count_now;
   assign rsp_chan.force_update_now  = rsp_ff.force_update_now;
   assign rsp_chan.boot_pending_now  = rsp_ff.boot_pending_now;

   // An event leaving the input register always shows up as a response
   `CLG_ASSERT_NXT(a_s1_to_rsp, clock, reset, s1_fire, rsp_valid_ff)
   // A decision and a cache match never report together
   `CLG_ASSERT_IMP(a_one_result, clock, reset, rsp_valid_ff,
                   !(rsp_ff.enter_update_mode && rsp_ff.cache_hit))
   // An update entered without force comes from a granted request: history cleared
   `CLG_ASSERT_IMP(a_grant_clears, clock, reset,
                   rsp_valid_ff && rsp_ff.enter_update_mode && !rsp_ff.force_update_now,
                   rsp_ff.failure_count_now == 8'd0 && !rsp_ff.boot_pending_now)

endmodule
